/* rtl/core/hc3_pkg.sv */
// ----------------------------------------------------------------------------
// hc3_pkg
// Shared types, register indexes and mod-26 helpers for the 3x3 Hill cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hc3_pkg;

   localparam int unsigned MODULUS   = 26;
   localparam int unsigned LETTER_W  = 5;
   localparam int unsigned ROW_W     = 3 * LETTER_W;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = ROW_W;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KEY_ROW_ZERO = 2'd0,
      CSR_KEY_ROW_ONE  = 2'd1,
      CSR_KEY_ROW_TWO  = 2'd2,
      CSR_DECRYPT_MODE = 2'd3
   } csr_index_type;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef letter_type [2:0]    vec_type;
   typedef vec_type [2:0]       mat_type;

   // raw key entries as written, one per row/column
   typedef struct packed {
      mat_type raw;
      logic    decrypt;
   } key_cfg_type;

   // effective matrix applied to the data
   typedef struct packed {
      mat_type mat;
      logic    invalid;
   } key_mat_type;

   // 5-bit value to 0..25
   function automatic letter_type red26(input letter_type x);
      letter_type r;
      r = x;
      if (x >= LETTER_W'(MODULUS)) begin
         r = x - LETTER_W'(MODULUS);
      end
      return r;
   endfunction

   // 11-bit value mod 26: quotient estimate by 157/4096 is low by at most one
   function automatic letter_type mod26(input logic [10:0] x);
      logic [18:0] prod;
      logic [6:0]  quo;
      logic [10:0] rem;
      prod = 19'(x) * 19'(157);
      quo  = prod[18:12];
      rem  = x - 11'(11'(quo) * 11'(MODULUS));
      if (rem >= 11'(MODULUS)) begin
         rem = rem - 11'(MODULUS);
      end
      return rem[LETTER_W-1:0];
   endfunction

   function automatic logic [9:0] mul5(input letter_type a, input letter_type b);
      return 10'(a) * 10'(b);
   endfunction

   // multiplicative inverse mod 26, zero where none exists
   function automatic letter_type inv26(input letter_type d);
      letter_type r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/hc3_key_path.sv */
// ----------------------------------------------------------------------------
// hc3_key_path
// Free-running six-stage pipeline that turns the key registers into the
// matrix applied to the data: the key itself, or its inverse mod 26.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hc3_key_path (
   input  logic                 clock,
   input  hc3_pkg::key_cfg_type key_cfg,
   output hc3_pkg::key_mat_type key_mat
);
   import hc3_pkg::*;

   // stage 1: reduced entries
   mat_type     k1_ff, k1_in;
   logic        dec1_ff;
   // stage 2: adjugate cross products
   logic [9:0]  pa2_ff [3][3];
   logic [9:0]  pb2_ff [3][3];
   logic [9:0]  pa2_in [3][3];
   logic [9:0]  pb2_in [3][3];
   mat_type     k2_ff;
   logic        dec2_ff;
   // stage 3: adjugate
   mat_type     adj3_ff, adj3_in;
   mat_type     k3_ff;
   logic        dec3_ff;
   // stage 4: determinant sum
   logic [10:0] dsum4_ff, dsum4_in;
   mat_type     adj4_ff, k4_ff;
   logic        dec4_ff;
   // stage 5: inverse of the determinant
   letter_type  dinv5_ff, dinv5_in;
   mat_type     adj5_ff, k5_ff;
   logic        dec5_ff;
   // stage 6: effective matrix
   key_mat_type km6_ff, km6_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            k1_in[i][j] = red26(key_cfg.raw[i][j]);
         end
      end
   end

   always_comb begin
      pa2_in[0][0] = mul5(k1_ff[1][1], k1_ff[2][2]);
      pb2_in[0][0] = mul5(k1_ff[1][2], k1_ff[2][1]);
      pa2_in[0][1] = mul5(k1_ff[0][2], k1_ff[2][1]);
      pb2_in[0][1] = mul5(k1_ff[0][1], k1_ff[2][2]);
      pa2_in[0][2] = mul5(k1_ff[0][1], k1_ff[1][2]);
      pb2_in[0][2] = mul5(k1_ff[0][2], k1_ff[1][1]);
      pa2_in[1][0] = mul5(k1_ff[1][2], k1_ff[2][0]);
      pb2_in[1][0] = mul5(k1_ff[1][0], k1_ff[2][2]);
      pa2_in[1][1] = mul5(k1_ff[0][0], k1_ff[2][2]);
      pb2_in[1][1] = mul5(k1_ff[0][2], k1_ff[2][0]);
      pa2_in[1][2] = mul5(k1_ff[0][2], k1_ff[1][0]);
      pb2_in[1][2] = mul5(k1_ff[0][0], k1_ff[1][2]);
      pa2_in[2][0] = mul5(k1_ff[1][0], k1_ff[2][1]);
      pb2_in[2][0] = mul5(k1_ff[1][1], k1_ff[2][0]);
      pa2_in[2][1] = mul5(k1_ff[0][1], k1_ff[2][0]);
      pb2_in[2][1] = mul5(k1_ff[0][0], k1_ff[2][1]);
      pa2_in[2][2] = mul5(k1_ff[0][0], k1_ff[1][1]);
      pb2_in[2][2] = mul5(k1_ff[0][1], k1_ff[1][0]);
   end

   always_comb begin
      logic [5:0] diff;
      diff = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            // keep the difference non-negative before folding
            diff = 6'(mod26(11'(pa2_ff[i][j]))) + 6'(MODULUS)
                   - 6'(mod26(11'(pb2_ff[i][j])));
            if (diff >= 6'(MODULUS)) begin
               diff = diff - 6'(MODULUS);
            end
            adj3_in[i][j] = diff[LETTER_W-1:0];
         end
      end
   end

   assign dsum4_in = 11'(mul5(k3_ff[0][0], adj3_ff[0][0]))
                   + 11'(mul5(k3_ff[0][1], adj3_ff[1][0]))
                   + 11'(mul5(k3_ff[0][2], adj3_ff[2][0]));

   assign dinv5_in = inv26(mod26(dsum4_ff));

   always_comb begin
      km6_in.invalid = dec5_ff && (dinv5_ff == '0);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (dec5_ff) begin
               km6_in.mat[i][j] = mod26(11'(mul5(adj5_ff[i][j], dinv5_ff)));
            end else begin
               km6_in.mat[i][j] = k5_ff[i][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      k1_ff    <= k1_in;
      dec1_ff  <= key_cfg.decrypt;
      pa2_ff   <= pa2_in;
      pb2_ff   <= pb2_in;
      k2_ff    <= k1_ff;
      dec2_ff  <= dec1_ff;
      adj3_ff  <= adj3_in;
      k3_ff    <= k2_ff;
      dec3_ff  <= dec2_ff;
      dsum4_ff <= dsum4_in;
      adj4_ff  <= adj3_ff;
      k4_ff    <= k3_ff;
      dec4_ff  <= dec3_ff;
      dinv5_ff <= dinv5_in;
      adj5_ff  <= adj4_ff;
      k5_ff    <= k4_ff;
      dec5_ff  <= dec4_ff;
      km6_ff   <= km6_in;
   end

   assign key_mat = km6_ff;

endmodule

/* rtl/core/hc3_data_path.sv */
// ----------------------------------------------------------------------------
// hc3_data_path
// Eight-stage letter pipeline with per-stage valid and stall. Letters ride
// alongside the key pipeline, then take the matrix product and the mod 26.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hc3_data_path (
   input  logic                 clock,
   input  logic                 reset,
   input  hc3_pkg::key_mat_type key_mat,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hc3_pkg::vec_type     in_letters,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hc3_pkg::vec_type     out_letters,
   output logic                 out_invalid
);
   import hc3_pkg::*;

   localparam int unsigned DEPTH    = 8;
   localparam int unsigned LET_LAST = DEPTH - 2;   // stage that takes the sums, after the last letter stage

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [DEPTH-1:0] rdy;
   vec_type          let_ff [LET_LAST];
   logic [10:0]      sum_ff [3];
   logic [10:0]      sum_in [3];
   vec_type          res_ff, res_in;
   logic             inv_ff;

   // a stage takes a new beat when it is empty or its successor moves on
   always_comb begin
      rdy[DEPTH-1] = !vld_ff[DEPTH-1] || out_ready;
      for (int s = DEPTH - 2; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end

   always_comb begin
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int s = 1; s < DEPTH; s++) begin
         vld_in[s] = rdy[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = 11'(mul5(key_mat.mat[i][0], let_ff[LET_LAST-1][0]))
                   + 11'(mul5(key_mat.mat[i][1], let_ff[LET_LAST-1][1]))
                   + 11'(mul5(key_mat.mat[i][2], let_ff[LET_LAST-1][2]));
         res_in[i] = key_mat.invalid ? '0 : mod26(sum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         for (int i = 0; i < 3; i++) begin
            let_ff[0][i] <= red26(in_letters[i]);
         end
      end
      for (int s = 1; s < LET_LAST; s++) begin
         if (rdy[s] && vld_ff[s-1]) begin
            let_ff[s] <= let_ff[s-1];
         end
      end
      if (rdy[LET_LAST] && vld_ff[LET_LAST-1]) begin
         sum_ff <= sum_in;
      end
      if (rdy[DEPTH-1] && vld_ff[DEPTH-2]) begin
         res_ff <= res_in;
         inv_ff <= key_mat.invalid;
      end
   end

   assign in_ready    = rdy[0];
   assign out_valid   = vld_ff[DEPTH-1];
   assign out_letters = res_ff;
   assign out_invalid = inv_ff;

endmodule

/* rtl/core/hill_cipher_3x3_block_top.sv */
// ----------------------------------------------------------------------------
// hill_cipher_3x3_block_top
// Hill cipher on three-letter blocks with a 3x3 key mod 26, encrypt or decrypt.
// Throughput: one block per cycle; the eight-stage letter pipeline stalls
// stage by stage from rsp_tready, so no beat is lost or repeated.
// Reset: key becomes the identity, encrypt mode, pipeline emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hill_cipher_3x3_block_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // letter_first, letter_second, letter_third, one zero pad bit
   input  logic [15:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // result_first, result_second, result_third, one zero pad bit
   output logic [15:0]                      rsp_tdata,
   // key_invalid
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [hc3_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [hc3_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hc3_pkg::*;

   logic [ROW_W-1:0] row0_ff, row1_ff, row2_ff;
   logic             decrypt_ff;
   key_cfg_type      key_cfg;
   key_mat_type      key_mat;
   vec_type          in_letters, out_letters;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff    <= ROW_W'(1);
         row1_ff    <= ROW_W'(32);
         row2_ff    <= ROW_W'(1024);
         decrypt_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_KEY_ROW_ZERO: row0_ff    <= csr_wdata;
            CSR_KEY_ROW_ONE:  row1_ff    <= csr_wdata;
            CSR_KEY_ROW_TWO:  row2_ff    <= csr_wdata;
            CSR_DECRYPT_MODE: decrypt_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         key_cfg.raw[0][j] = row0_ff[j*LETTER_W +: LETTER_W];
         key_cfg.raw[1][j] = row1_ff[j*LETTER_W +: LETTER_W];
         key_cfg.raw[2][j] = row2_ff[j*LETTER_W +: LETTER_W];
         in_letters[j]     = req_tdata[j*LETTER_W +: LETTER_W];
      end
      key_cfg.decrypt = decrypt_ff;
   end

   hc3_key_path u_key_path (
      .clock   (clock),
      .key_cfg (key_cfg),
      .key_mat (key_mat)
   );

   hc3_data_path u_data_path (
      .clock       (clock),
      .reset       (reset),
      .key_mat     (key_mat),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_letters  (in_letters),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_letters (out_letters),
      .out_invalid (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, out_letters[2], out_letters[1], out_letters[0]};

endmodule
